// ===== design/isc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the stack calculator.
package isc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int STAT_W      = 3;

    localparam logic [FUNC_W-1:0] OP_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_ADD  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SUB  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_MUL  = 3'd4;
    localparam logic [FUNC_W-1:0] OP_DIV  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FEW     = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic                latch_in;
        logic                mem_we;
        logic                mem_re;
        logic [ADDR_W-1:0]   mem_addr;
        logic                wr_res;
        logic                right_ld;
        logic                left_ld;
        logic                alu_ld;
        logic                div_start;
        logic                div_ld;
        logic                pop_ld;
        logic                load_out;
        logic                out_zero;
        logic [STAT_W-1:0]   out_status;
        logic [COUNT_W-1:0]  out_depth;
        logic [FUNC_W-1:0]   op;
    } isc_cmd_t;

    typedef struct packed {
        logic right_zero;
        logic div_done;
    } isc_stat_t;

endpackage

// ===== design/integer_stack_calculator.sv =====
// Integer stack calculator: a 1024-entry stack of signed 32-bit words with
// push, pop, add, subtract, multiply and floor divide on the top two entries.
// One beat in gives one beat out. Items are processed one at a time; a new
// item is taken only after the last one is loaded into the output register.
// An item is refused on entry on a full or empty stack, too few operands or an
// unused code. Add, subtract and multiply take two reads of the single-port
// stack RAM, the ALU step and the write back; divide runs the radix-2 divider
// that produces one quotient bit per cycle, and a divide by zero skips it.
// The output register holds a finished beat while the next item is taken in.
// The stack RAM needs no clearing after reset; only entries below the current
// depth are ever read.
module integer_stack_calculator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic        [isc_pkg::FUNC_W-1:0]   func,
    input  logic signed [isc_pkg::WORD_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [isc_pkg::WORD_W-1:0]   value,
    output logic        [isc_pkg::STAT_W-1:0]   status,
    output logic        [isc_pkg::COUNT_W-1:0]  depth
);

    isc_pkg::isc_cmd_t               cmd;
    isc_pkg::isc_stat_t              st;
    logic [isc_pkg::WORD_W-1:0]      value_u;

    isc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    isc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value ($unsigned(push_value)),
        .cmd        (cmd),
        .st         (st),
        .value      (value_u),
        .status     (status),
        .depth      (depth)
    );

    assign value = $signed(value_u);

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth <= isc_pkg::COUNT_W'(isc_pkg::STACK_DEPTH))
        else $error("depth beyond stack size");

    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == isc_pkg::ST_FULL) |->
            depth == isc_pkg::COUNT_W'(isc_pkg::STACK_DEPTH))
        else $error("full status with room left");

    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == isc_pkg::ST_EMPTY) |-> depth == '0)
        else $error("empty status with entries present");

    a_few_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == isc_pkg::ST_FEW) |->
            depth < isc_pkg::COUNT_W'(2))
        else $error("operand shortage reported with two or more entries");
`endif

endmodule

// ===== design/isc_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module isc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [isc_pkg::WORD_W-1:0]  dividend,
    input  logic [isc_pkg::WORD_W-1:0]  divisor,
    output logic [isc_pkg::WORD_W-1:0]  quotient,
    output logic [isc_pkg::WORD_W-1:0]  remainder,
    output logic                        done
);

    localparam int W   = isc_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     dsr_reg;
    logic [W-1:0]     dsr_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== design/isc_datapath.sv =====
// Stack memory, operand registers, ALU, floor-division fixup and output payload registers.
module isc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [isc_pkg::WORD_W-1:0]   push_value,
    input  isc_pkg::isc_cmd_t            cmd,
    output isc_pkg::isc_stat_t           st,
    output logic [isc_pkg::WORD_W-1:0]   value,
    output logic [isc_pkg::STAT_W-1:0]   status,
    output logic [isc_pkg::COUNT_W-1:0]  depth
);

    localparam int W = isc_pkg::WORD_W;

    logic [W-1:0]                  stack_mem [isc_pkg::STACK_DEPTH];
    logic [W-1:0]                  rdata_reg;
    logic [W-1:0]                  word_reg;
    logic [W-1:0]                  right_reg;
    logic [W-1:0]                  left_reg;
    logic [W-1:0]                  res_reg;
    logic [W-1:0]                  res_next;
    logic                          sdiff_reg;
    logic [W-1:0]                  value_reg;
    logic [isc_pkg::STAT_W-1:0]    status_reg;
    logic [isc_pkg::COUNT_W-1:0]   depth_reg;
    logic [W-1:0]                  wdata;
    logic [W-1:0]                  alu_out;
    logic [2*W-1:0]                product;
    logic [W-1:0]                  mag_left;
    logic [W-1:0]                  mag_right;
    logic [W-1:0]                  quo;
    logic [W-1:0]                  rem;
    logic [W-1:0]                  quo_fix;
    logic                          div_done;

    assign wdata = cmd.wr_res ? res_reg : word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            stack_mem[cmd.mem_addr] <= wdata;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= stack_mem[cmd.mem_addr];
        end
    end

    assign product = {{W{1'b0}}, left_reg} * {{W{1'b0}}, right_reg};

    always_comb
    begin
        case (cmd.op)
            isc_pkg::OP_SUB: alu_out = left_reg - right_reg;
            isc_pkg::OP_MUL: alu_out = product[W-1:0];
            default:         alu_out = left_reg + right_reg;
        endcase
    end

    assign mag_left  = left_reg[W-1]  ? (W'(0) - left_reg)  : left_reg;
    assign mag_right = right_reg[W-1] ? (W'(0) - right_reg) : right_reg;

    isc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (mag_left),
        .divisor   (mag_right),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    // floor: -q when exact, -q-1 (= ~q) otherwise
    always_comb
    begin
        if (!sdiff_reg)
        begin
            quo_fix = quo;
        end
        else if (rem != '0)
        begin
            quo_fix = ~quo;
        end
        else
        begin
            quo_fix = W'(0) - quo;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.pop_ld)
        begin
            res_next = rdata_reg;
        end
        else if (cmd.alu_ld)
        begin
            res_next = alu_out;
        end
        else if (cmd.div_ld)
        begin
            res_next = quo_fix;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.latch_in)
        begin
            word_reg <= push_value;
        end
        if (cmd.right_ld)
        begin
            right_reg <= rdata_reg;
        end
        if (cmd.left_ld)
        begin
            left_reg <= rdata_reg;
        end
        if (cmd.div_start)
        begin
            sdiff_reg <= left_reg[W-1] ^ right_reg[W-1];
        end
        if (cmd.load_out)
        begin
            value_reg  <= cmd.out_zero ? '0 : res_reg;
            status_reg <= cmd.out_status;
            depth_reg  <= cmd.out_depth;
        end
    end

    assign st.right_zero = (right_reg == '0);
    assign st.div_done   = div_done;
    assign value         = value_reg;
    assign status        = status_reg;
    assign depth         = depth_reg;

endmodule

// ===== design/isc_ctrl.sv =====
// Controller state machine: decodes operations, tracks the entry count, sequences the datapath.
module isc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [isc_pkg::FUNC_W-1:0]   func,
    output logic                         out_valid,
    input  logic                         out_stall,
    output isc_pkg::isc_cmd_t            cmd,
    input  isc_pkg::isc_stat_t           st
);

    localparam int CW = isc_pkg::COUNT_W;
    localparam int AW = isc_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_WR,
        S_POP_RD,
        S_POP_WAIT,
        S_RD_TOP,
        S_RD_SEC,
        S_RD_WAIT,
        S_EXEC,
        S_DIV_WAIT,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [isc_pkg::FUNC_W-1:0]  func_reg;
    logic [isc_pkg::FUNC_W-1:0]  func_next;
    logic [isc_pkg::STAT_W-1:0]  code_reg;
    logic [isc_pkg::STAT_W-1:0]  code_next;
    logic                        zero_reg;
    logic                        zero_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [CW-1:0]               count_m1;
    logic [CW-1:0]               count_m2;
    logic                        full;
    logic                        accept;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign full     = (count_reg >= CW'(isc_pkg::STACK_DEPTH));
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        func_next  = func_reg;
        code_next  = code_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        cmd.op         = func_reg;
        cmd.out_zero   = zero_reg;
        cmd.out_status = code_reg;
        cmd.out_depth  = count_reg;
        cmd.mem_addr   = count_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_in = 1'b1;
                    func_next    = func;
                    code_next    = isc_pkg::ST_OK;
                    zero_next    = 1'b1;
                    case (func)
                        isc_pkg::OP_PUSH:
                        begin
                            if (full)
                            begin
                                code_next  = isc_pkg::ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_PUSH_WR;
                            end
                        end
                        isc_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                code_next  = isc_pkg::ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        isc_pkg::OP_ADD, isc_pkg::OP_SUB, isc_pkg::OP_MUL, isc_pkg::OP_DIV:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                code_next  = isc_pkg::ST_FEW;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RD_TOP;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUSH_WR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.mem_addr = count_reg[AW-1:0];
                count_next   = count_reg + CW'(1);
                state_next   = S_FINISH;
            end
            S_POP_RD:
            begin
                cmd.mem_re = 1'b1;
                count_next = count_m1;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                cmd.pop_ld = 1'b1;
                zero_next  = 1'b0;
                state_next = S_FINISH;
            end
            S_RD_TOP:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_RD_SEC;
            end
            S_RD_SEC:
            begin
                cmd.mem_re   = 1'b1;
                cmd.mem_addr = count_m2[AW-1:0];
                cmd.right_ld = 1'b1;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.left_ld = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (func_reg == isc_pkg::OP_DIV)
                begin
                    if (st.right_zero)
                    begin
                        code_next  = isc_pkg::ST_DIVZERO;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_WAIT;
                    end
                end
                else
                begin
                    cmd.alu_ld = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.div_ld = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.mem_we   = 1'b1;
                cmd.wr_res   = 1'b1;
                cmd.mem_addr = count_m2[AW-1:0];
                count_next   = count_m1;
                zero_next    = 1'b0;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            func_reg      <= isc_pkg::OP_PUSH;
            code_reg      <= isc_pkg::ST_OK;
            zero_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            func_reg      <= func_next;
            code_reg      <= code_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
